// File: design/sps_pkg.sv
// shared constants, state codes and control structs of the shortest path unit
`timescale 1ns / 1ps
package sps_pkg;

  localparam int MAX_NODES_DEF   = 1024;
  localparam int MAX_EDGES_DEF   = 4096;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int DIST_BITS_DEF   = 32;

  localparam int NODE_W   = 10;
  localparam int WEIGHT_W = 16;
  localparam int LEN_W    = 28;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [13:0] {
    S_CLR      = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_LD_WR    = 14'b00000000000100,
    S_QCHK     = 14'b00000000001000,
    S_INIT     = 14'b00000000010000,
    S_SCAN     = 14'b00000000100000,
    S_SCAN_END = 14'b00000001000000,
    S_DECIDE   = 14'b00000010000000,
    S_SETTLE   = 14'b00000100000000,
    S_HEAD_DAT = 14'b00001000000000,
    S_E_DAT    = 14'b00010000000000,
    S_D_DAT    = 14'b00100000000000,
    S_FIN_CLR  = 14'b01000000000000,
    S_RES      = 14'b10000000000000
  } state_t;

  typedef struct packed {
    logic capture;
    logic ld_write;
    logic cnt_rst;
    logic cnt_one;
    logic init_wr;
    logic clr_wr;
    logic scan_rd;
    logic set_found;
    logic set_miss;
    logic settle;
    logic e_rd_head;
    logic e_dat;
    logic relax;
    logic e_rd_link;
    logic out_load;
    logic used_clr;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic scan_last;
    logic qvalid;
    logic is_query;
    logic best_inf;
    logic best_dst;
    logic head_zero;
    logic link_zero;
    logic out_full;
  } sts_t;

endpackage

// File: design/single_pair_shortest_path_unit.sv
// top level of the single pair shortest path unit
//
//  channel  direction  handshake           payload
//  in       input      in_valid/in_ready   operation, edge, query fields
//  out      output     out_valid/out_ready reachable, path_length
//
// an edge load is a head list read then an edge write
// a query runs a check and an init pass over all MAX_NODES distance entries, then
// per settled node a scan of nodes up to node_count and a walk of its edges, then
// a clearing pass over all MAX_NODES head list entries and a result step
// after reset a clearing pass over all head list entries runs before the first item
// a result waits in the output register; loads are taken while it waits
`timescale 1ns / 1ps
module single_pair_shortest_path_unit #(
  parameter int MAX_NODES   = sps_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES   = sps_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = sps_pkg::WEIGHT_BITS_DEF,
  parameter int DIST_BITS   = sps_pkg::DIST_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_operation,
  input  logic [sps_pkg::NODE_W-1:0]   in_edge_from,
  input  logic [sps_pkg::NODE_W-1:0]   in_edge_to,
  input  logic [sps_pkg::WEIGHT_W-1:0] in_edge_weight,
  input  logic [sps_pkg::NODE_W-1:0]   in_source_node,
  input  logic [sps_pkg::NODE_W-1:0]   in_target_node,
  input  logic [sps_pkg::NODE_W-1:0]   in_node_count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_reachable,
  output logic [sps_pkg::LEN_W-1:0]    out_path_length
);

  sps_pkg::cmd_t cmd;
  sps_pkg::sts_t sts;

  sps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sps_datapath #(
    .MAX_NODES   (MAX_NODES),
    .MAX_EDGES   (MAX_EDGES),
    .WEIGHT_BITS (WEIGHT_BITS),
    .DIST_BITS   (DIST_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_operation),
    .in_edge_from    (in_edge_from),
    .in_edge_to      (in_edge_to),
    .in_edge_weight  (in_edge_weight),
    .in_source_node  (in_source_node),
    .in_target_node  (in_target_node),
    .in_node_count   (in_node_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_reachable   (out_reachable),
    .out_path_length (out_path_length)
  );

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operation == sps_pkg::OP_QUERY) |=> !in_ready)
    else $error("input taken during a query");

  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operation == sps_pkg::OP_LOAD) |=> !in_ready && !$rose(out_valid))
    else $error("edge load misbehaved");

  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a query");

  a_unreach_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_reachable) |-> (out_path_length == '0))
    else $error("length given for unreachable target");

endmodule

// File: design/sps_ctrl.sv
// controller state machine of the shortest path unit
`timescale 1ns / 1ps
module sps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sps_pkg::sts_t sts,
  output sps_pkg::cmd_t cmd
);

  sps_pkg::state_t state_r, state_nxt;
  logic accept;

  assign in_ready = (state_r == sps_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sps_pkg::S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.capture = accept;
    unique case (state_r)
      sps_pkg::S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = sps_pkg::S_IDLE;
        end
      end
      sps_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = sts.is_query ? sps_pkg::S_QCHK : sps_pkg::S_LD_WR;
        end
      end
      sps_pkg::S_LD_WR: begin
        cmd.ld_write = 1'b1;
        state_nxt = sps_pkg::S_IDLE;
      end
      sps_pkg::S_QCHK: begin
        cmd.cnt_rst = 1'b1;
        if (sts.qvalid) begin
          state_nxt = sps_pkg::S_INIT;
        end else begin
          cmd.set_miss = 1'b1;
          state_nxt = sps_pkg::S_FIN_CLR;
        end
      end
      sps_pkg::S_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.sweep_last) begin
          cmd.cnt_one = 1'b1;
          state_nxt = sps_pkg::S_SCAN;
        end
      end
      sps_pkg::S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_nxt = sps_pkg::S_SCAN_END;
        end
      end
      sps_pkg::S_SCAN_END: begin
        state_nxt = sps_pkg::S_DECIDE;
      end
      sps_pkg::S_DECIDE: begin
        priority if (sts.best_inf) begin
          cmd.set_miss = 1'b1;
          cmd.cnt_rst = 1'b1;
          state_nxt = sps_pkg::S_FIN_CLR;
        end else if (sts.best_dst) begin
          cmd.set_found = 1'b1;
          cmd.cnt_rst = 1'b1;
          state_nxt = sps_pkg::S_FIN_CLR;
        end else begin
          state_nxt = sps_pkg::S_SETTLE;
        end
      end
      sps_pkg::S_SETTLE: begin
        cmd.settle = 1'b1;
        state_nxt = sps_pkg::S_HEAD_DAT;
      end
      sps_pkg::S_HEAD_DAT: begin
        if (sts.head_zero) begin
          cmd.cnt_one = 1'b1;
          state_nxt = sps_pkg::S_SCAN;
        end else begin
          cmd.e_rd_head = 1'b1;
          state_nxt = sps_pkg::S_E_DAT;
        end
      end
      sps_pkg::S_E_DAT: begin
        cmd.e_dat = 1'b1;
        state_nxt = sps_pkg::S_D_DAT;
      end
      sps_pkg::S_D_DAT: begin
        cmd.relax = 1'b1;
        if (sts.link_zero) begin
          cmd.cnt_one = 1'b1;
          state_nxt = sps_pkg::S_SCAN;
        end else begin
          cmd.e_rd_link = 1'b1;
          state_nxt = sps_pkg::S_E_DAT;
        end
      end
      sps_pkg::S_FIN_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.sweep_last) begin
          cmd.used_clr = 1'b1;
          state_nxt = sps_pkg::S_RES;
        end
      end
      sps_pkg::S_RES: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt = sps_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sps_pkg::S_CLR;
      end
    endcase
  end

endmodule

// File: design/sps_datapath.sv
// datapath of the shortest path unit: edge lists, distance table, scan and relax
`timescale 1ns / 1ps
module sps_datapath #(
  parameter int MAX_NODES   = sps_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES   = sps_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = sps_pkg::WEIGHT_BITS_DEF,
  parameter int DIST_BITS   = sps_pkg::DIST_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sps_pkg::cmd_t                cmd,
  output sps_pkg::sts_t                sts,
  input  logic                         in_operation,
  input  logic [sps_pkg::NODE_W-1:0]   in_edge_from,
  input  logic [sps_pkg::NODE_W-1:0]   in_edge_to,
  input  logic [sps_pkg::WEIGHT_W-1:0] in_edge_weight,
  input  logic [sps_pkg::NODE_W-1:0]   in_source_node,
  input  logic [sps_pkg::NODE_W-1:0]   in_target_node,
  input  logic [sps_pkg::NODE_W-1:0]   in_node_count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_reachable,
  output logic [sps_pkg::LEN_W-1:0]    out_path_length
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int WB = WEIGHT_BITS;
  localparam int DV = DIST_BITS - 1;
  localparam int SW = ((DV > WB) ? DV : WB) + 1;
  localparam int XW = DV + sps_pkg::LEN_W;
  localparam int EDW = NW + WB + EW;
  localparam logic [DV-1:0] INF = {DV{1'b1}};
  localparam logic [NW-1:0] LAST_NODE = NW'(MAX_NODES - 1);

  logic [EW-1:0]  head_mem [MAX_NODES];
  logic [EDW-1:0] edge_mem [MAX_EDGES];
  logic [DV:0]    dist_mem [MAX_NODES];

  logic [NW-1:0] from_r, to_r, src_r, dst_r, lim_r, cnt_r, bestn_r, pend_n_r, v_r;
  logic [WB-1:0] w_r, ew_r;
  logic          ok_r, qvalid_r, pend_v_r;
  logic [EW-1:0] used_r, head_q, link_r;
  logic [EDW-1:0] eq;
  logic [DV:0]   dq;
  logic [DV-1:0] best_r;
  logic          res_ok_r, out_valid_r, out_reach_r;
  logic [sps_pkg::LEN_W-1:0] res_len_r, out_len_r;

  logic [31:0]   lim_w;
  logic [NW-1:0] head_rd_addr, dist_rd_addr;
  logic [EA-1:0] edge_rd_addr;
  logic [NW-1:0] eq_to;
  logic [WB-1:0] eq_w;
  logic [EW-1:0] eq_link;
  logic [SW-1:0] nd;
  logic [DV-1:0] nd_sat;
  logic          v_ok;
  logic [XW-1:0] best_x;

  assign lim_w = (32'(in_node_count) > 32'(MAX_NODES - 1)) ? 32'(MAX_NODES - 1)
                                                             : 32'(in_node_count);
  assign {eq_to, eq_w, eq_link} = eq;
  assign head_rd_addr = cmd.settle ? bestn_r : NW'(in_edge_from);
  assign edge_rd_addr = cmd.e_rd_head ? EA'(head_q - EW'(1)) : EA'(link_r - EW'(1));
  assign dist_rd_addr = cmd.e_dat ? eq_to : cnt_r;

  assign nd     = SW'(best_r) + SW'(ew_r);
  assign nd_sat = (nd > SW'(INF)) ? INF : DV'(nd);
  assign v_ok   = (v_r != '0) && (v_r <= lim_r) && !dq[DV] && (nd_sat < dq[DV-1:0]);
  assign best_x = XW'(best_r);

  // memories
  always_ff @(posedge clk) begin
    head_q <= head_mem[head_rd_addr];
    if (cmd.ld_write && ok_r) begin
      head_mem[from_r] <= used_r + EW'(1);
    end else if (cmd.clr_wr) begin
      head_mem[cnt_r] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    eq <= edge_mem[edge_rd_addr];
    if (cmd.ld_write && ok_r) begin
      edge_mem[EA'(used_r)] <= {to_r, w_r, head_q};
    end
  end

  always_ff @(posedge clk) begin
    dq <= dist_mem[dist_rd_addr];
    if (cmd.init_wr) begin
      dist_mem[cnt_r] <= (cnt_r == src_r) ? '0 : {1'b0, INF};
    end else if (cmd.settle) begin
      dist_mem[bestn_r] <= {1'b1, best_r};
    end else if (cmd.relax && v_ok) begin
      dist_mem[v_r] <= {1'b0, nd_sat};
    end
  end

  // payload capture and edge walk registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      from_r   <= NW'(in_edge_from);
      to_r     <= NW'(in_edge_to);
      w_r      <= WB'(in_edge_weight);
      src_r    <= NW'(in_source_node);
      dst_r    <= NW'(in_target_node);
      lim_r    <= NW'(lim_w);
      ok_r     <= (32'(used_r) < 32'(MAX_EDGES)) && (32'(in_edge_from) < 32'(MAX_NODES)) &&
                  (32'(in_edge_to) < 32'(MAX_NODES));
      qvalid_r <= (in_source_node != '0) && (32'(in_source_node) <= lim_w) &&
                  (in_target_node != '0) && (32'(in_target_node) <= lim_w);
    end
    if (cmd.e_dat) begin
      v_r    <= eq_to;
      link_r <= eq_link;
    end else if (cmd.e_rd_head) begin
      link_r <= head_q;
    end
    if (cmd.e_dat) begin
      ew_r <= eq_w;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      used_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_rst) begin
        cnt_r <= '0;
      end else if (cmd.cnt_one) begin
        cnt_r <= NW'(1);
      end else if (cmd.init_wr || cmd.clr_wr || cmd.scan_rd) begin
        cnt_r <= cnt_r + NW'(1);
      end
      if (cmd.used_clr) begin
        used_r <= '0;
      end else if (cmd.ld_write && ok_r) begin
        used_r <= used_r + EW'(1);
      end
      pend_v_r <= cmd.scan_rd;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // minimum search over unsettled nodes and result
  always_ff @(posedge clk) begin
    pend_n_r <= cnt_r;
    if (cmd.cnt_one) begin
      best_r <= INF;
    end else if (pend_v_r && !dq[DV] && (dq[DV-1:0] < best_r)) begin
      best_r  <= dq[DV-1:0];
      bestn_r <= pend_n_r;
    end
    if (cmd.set_found) begin
      res_ok_r  <= 1'b1;
      res_len_r <= (best_x > XW'(sps_pkg::LEN_MAX)) ? sps_pkg::LEN_MAX
                                                    : best_x[sps_pkg::LEN_W-1:0];
    end else if (cmd.set_miss) begin
      res_ok_r  <= 1'b0;
      res_len_r <= '0;
    end
    if (cmd.out_load) begin
      out_reach_r <= res_ok_r;
      out_len_r   <= res_len_r;
    end
  end

  assign sts.sweep_last = (cnt_r == LAST_NODE);
  assign sts.scan_last  = (cnt_r == lim_r);
  assign sts.qvalid     = qvalid_r;
  assign sts.is_query   = (in_operation == sps_pkg::OP_QUERY);
  assign sts.best_inf   = (best_r == INF);
  assign sts.best_dst   = (bestn_r == dst_r);
  assign sts.head_zero  = (head_q == '0);
  assign sts.link_zero  = (link_r == '0);
  assign sts.out_full   = out_valid_r;

  assign out_valid       = out_valid_r;
  assign out_reachable   = out_reach_r;
  assign out_path_length = out_len_r;

endmodule

// File: tb/single_pair_shortest_path_unit_test.sv
// testbench for the single pair shortest path unit: edge loads, queries, predicted results
`timescale 1ns / 1ps
module single_pair_shortest_path_unit_test;

  localparam int EDGE_CAP = sps_pkg::MAX_EDGES_DEF;
  localparam int NODE_TOP = sps_pkg::MAX_NODES_DEF - 1;
  localparam longint DIST_INF = (64'd1 << (sps_pkg::DIST_BITS_DEF - 1)) - 1;

  typedef struct packed {
    logic                      found;
    logic [sps_pkg::LEN_W-1:0] length;
  } route_t;

  class path_scoreboard;
    int unsigned tail_of[EDGE_CAP];
    int unsigned head_of[EDGE_CAP];
    int unsigned weight_of[EDGE_CAP];
    int unsigned edge_total;
    route_t pending_routes[$];

    function void clear_graph();
      edge_total = 0;
    endfunction

    function route_t shortest_route(int unsigned src, int unsigned dst, int unsigned cnt);
      longint best[sps_pkg::MAX_NODES_DEF];
      bit done[sps_pkg::MAX_NODES_DEF];
      int unsigned lim;
      int unsigned u;
      longint nd;
      longint low;
      route_t r;
      lim = (cnt > NODE_TOP) ? NODE_TOP : cnt;
      r = '0;
      if (src < 1 || src > lim || dst < 1 || dst > lim) return r;
      for (int i = 0; i < sps_pkg::MAX_NODES_DEF; i++) begin
        best[i] = DIST_INF;
        done[i] = 0;
      end
      best[src] = 0;
      forever begin
        low = DIST_INF;
        u = 0;
        for (int unsigned i = 1; i <= lim; i++) begin
          if (!done[i] && best[i] < low) begin
            low = best[i];
            u = i;
          end
        end
        if (u == 0) return r;
        done[u] = 1;
        if (u == dst) begin
          r.found = 1'b1;
          r.length = (best[u] > longint'(sps_pkg::LEN_MAX)) ? sps_pkg::LEN_MAX
                                                            : best[u][sps_pkg::LEN_W-1:0];
          return r;
        end
        for (int unsigned k = 0; k < edge_total; k++) begin
          if (tail_of[k] == u && head_of[k] >= 1 && head_of[k] <= lim && !done[head_of[k]]) begin
            nd = best[u] + weight_of[k];
            if (nd > DIST_INF) nd = DIST_INF;
            if (nd < best[head_of[k]]) best[head_of[k]] = nd;
          end
        end
      end
    endfunction

    function void note_item(logic op, int unsigned f, int unsigned t, int unsigned w,
                            int unsigned s, int unsigned d, int unsigned n);
      if (op == sps_pkg::OP_LOAD) begin
        if (edge_total < EDGE_CAP) begin
          tail_of[edge_total] = f;
          head_of[edge_total] = t;
          weight_of[edge_total] = w;
          edge_total++;
        end
      end else begin
        pending_routes = {pending_routes, shortest_route(s, d, n)};
        clear_graph();
      end
    endfunction

    function bit check_result(logic found, logic [sps_pkg::LEN_W-1:0] length,
                              output string why);
      route_t e;
      if (pending_routes.size() == 0) begin
        why = $sformatf("unexpected result reachable=%0d length=%0d", found, length);
        return 0;
      end
      e = pending_routes.pop_front();
      why = "";
      if (found !== e.found)
        why = $sformatf("reachable %0d, want %0d", found, e.found);
      else if (length !== e.length)
        why = $sformatf("path_length %0d, want %0d", length, e.length);
      return why == "";
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic in_operation = sps_pkg::OP_LOAD;
  logic [sps_pkg::NODE_W-1:0] in_edge_from = '0;
  logic [sps_pkg::NODE_W-1:0] in_edge_to = '0;
  logic [sps_pkg::WEIGHT_W-1:0] in_edge_weight = '0;
  logic [sps_pkg::NODE_W-1:0] in_source_node = '0;
  logic [sps_pkg::NODE_W-1:0] in_target_node = '0;
  logic [sps_pkg::NODE_W-1:0] in_node_count = '0;
  logic out_valid;
  logic out_ready = 0;
  logic out_reachable;
  logic [sps_pkg::LEN_W-1:0] out_path_length;

  path_scoreboard routes = new();
  int mismatches = 0;
  int results_seen = 0;
  bit calm = 0;

  always #5 clk = ~clk;

  single_pair_shortest_path_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_edge_from(in_edge_from), .in_edge_to(in_edge_to),
    .in_edge_weight(in_edge_weight), .in_source_node(in_source_node),
    .in_target_node(in_target_node), .in_node_count(in_node_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_reachable(out_reachable), .out_path_length(out_path_length)
  );

  task report(input string why);
    $display("mismatch at %0t: %s", $realtime, why);
    mismatches++;
  endtask

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task send_item(input logic op, input int unsigned f, input int unsigned t,
                 input int unsigned w, input int unsigned s, input int unsigned d,
                 input int unsigned n);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_operation <= op;
    in_edge_from <= sps_pkg::NODE_W'(f);
    in_edge_to <= sps_pkg::NODE_W'(t);
    in_edge_weight <= sps_pkg::WEIGHT_W'(w);
    in_source_node <= sps_pkg::NODE_W'(s);
    in_target_node <= sps_pkg::NODE_W'(d);
    in_node_count <= sps_pkg::NODE_W'(n);
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task load_edge(input int unsigned f, input int unsigned t, input int unsigned w);
    send_item(sps_pkg::OP_LOAD, f, t, w, $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 1023));
  endtask

  task ask(input int unsigned s, input int unsigned d, input int unsigned n);
    send_item(sps_pkg::OP_QUERY, $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 65535), s, d, n);
  endtask

  function int unsigned pick_node(int unsigned n);
    if ($urandom_range(0, 19) == 0) return $urandom_range(0, 1023);
    return $urandom_range(1, n);
  endfunction

  // random graph with a query on it
  task random_case(output int unsigned count);
    int unsigned n;
    int unsigned edges;
    int r;
    r = $urandom_range(0, 99);
    n = (r < 6) ? $urandom_range(900, 1023) : $urandom_range(2, 14);
    edges = $urandom_range(0, 3 * n > 24 ? 24 : 3 * n);
    for (int i = 0; i < edges; i++)
      load_edge(pick_node(n), pick_node(n),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40));
    if (r >= 95) ask($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
    else ask(pick_node(n), pick_node(n), n);
    count = edges + 1;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      routes.note_item(in_operation, in_edge_from, in_edge_to, in_edge_weight,
                       in_source_node, in_target_node, in_node_count);
  end

  always @(posedge clk) begin
    string why;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (!routes.check_result(out_reachable, out_path_length, why)) report(why);
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int gap;
    bit held;
    held = 0;
    gap = 0;
    forever begin
      @(posedge clk);
      if (!held && results_seen == 40) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (12000) @(posedge clk);
      end
      if (gap > 0) begin
        gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        gap = pick_gap();
      end
    end
  end

  initial begin
    #400_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned count;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes and corner cases
    load_edge(1023, 1, 65535);
    load_edge(1, 2, 0);
    load_edge(0, 2, 1);
    load_edge(2, 0, 1);
    load_edge(2, 1023, 7);
    ask(1023, 2, 1023);
    load_edge(3, 3, 5);
    ask(3, 3, 4);
    load_edge(1, 2, 9);
    ask(0, 2, 5);
    load_edge(1, 2, 9);
    ask(1, 0, 5);
    load_edge(1, 2, 9);
    ask(1, 2, 0);
    load_edge(1, 5, 9);
    ask(1, 5, 4);
    load_edge(2, 1, 9);
    ask(1, 2, 3);
    ask(512, 512, 1023);
    load_edge(682, 341, 43690);
    load_edge(341, 682, 21845);
    ask(341, 682, 700);

    sent = 0;
    while (sent < 1350) begin
      if ($urandom_range(0, 29) == 0) calm = ~calm;
      random_case(count);
      sent += count;
    end
    in_valid <= 1'b0;

    while (routes.pending_routes.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (mismatches == 0 && routes.pending_routes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
design/sps_pkg.sv
design/sps_ctrl.sv
design/sps_datapath.sv
design/single_pair_shortest_path_unit.sv
tb/single_pair_shortest_path_unit_test.sv
